[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while in reset.
`define SRR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while in reset.
`define SRR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/srr_pkg.sv]
package srr_pkg;

  localparam int SampleW  = 24;
  localparam int DampW    = 10;
  localparam int PlacesW  = 3;
  localparam int ThrW     = 23;
  localparam int CfgW     = 23;
  localparam int CfgIdxW  = 2;

  // |average*damping + sample| fits in DivW bits
  localparam int ProdW    = SampleW - 1 + DampW;
  localparam int DivW     = SampleW + DampW;
  localparam int NumW     = DivW + 1;
  localparam int DvsW     = 17;
  localparam int StepW    = 14;
  localparam int V10W     = SampleW + 5;
  localparam int MagW     = SampleW + StepW;
  localparam int CmpW     = ((SampleW > ThrW) ? SampleW : ThrW) + 1;
  localparam int DivCntW  = $clog2(DivW + 1);

  localparam longint NoSampleVal =
    (SampleW >= 21) ? -64'sd1000000 : -(64'sd1 <<< (SampleW - 1));
  localparam logic signed [SampleW-1:0] NoSample = SampleW'(NoSampleVal);

  localparam logic [DampW-1:0]          DampReset   = DampW'(100);
  localparam logic signed [PlacesW-1:0] PlacesReset = -PlacesW'(1);
  localparam logic [ThrW-1:0]           ThrReset    = ThrW'(100000);

  typedef enum logic [CfgIdxW-1:0] {
    CfgDamping   = 2'd0,
    CfgPlaces    = 2'd1,
    CfgThreshold = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FanNone = 2'd0,
    FanOn   = 2'd1,
    FanOff  = 2'd2
  } fan_cmd_e;

  typedef enum logic [1:0] {
    FanIsOff   = 2'd0,
    FanIsOn    = 2'd1,
    FanUnknown = 2'd2
  } fan_state_e;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StDiv1Start,
    StDiv1Wait,
    StHyst,
    StDiv2Wait,
    StScale,
    StFinish
  } srr_state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic div1_start;
    logic avg_take;
    logic hyst;
    logic scale;
    logic finish;
  } srr_cmd_t;

  typedef struct packed {
    logic avg_neg;
    logic hold;
    logic div_done;
  } srr_status_t;

  // decimal exponent of the reporting step, in hundredths
  function automatic logic [2:0] places_exp(input logic signed [PlacesW-1:0] p);
    logic [2:0] e;
    if (p < -2) e = 3'd4;
    else if (p > 2) e = 3'd0;
    else e = 3'(2 - int'(p));
    return e;
  endfunction

  function automatic logic [DvsW-1:0] step_of(input logic [2:0] e);
    logic [DvsW-1:0] v;
    case (e)
      3'd0:    v = DvsW'(1);
      3'd1:    v = DvsW'(10);
      3'd2:    v = DvsW'(100);
      3'd3:    v = DvsW'(1000);
      default: v = DvsW'(10000);
    endcase
    return v;
  endfunction

  function automatic logic [DvsW-1:0] hyst_of(input logic [2:0] e);
    logic [DvsW-1:0] v;
    case (e)
      3'd0:    v = DvsW'(3);
      3'd1:    v = DvsW'(30);
      3'd2:    v = DvsW'(300);
      3'd3:    v = DvsW'(3000);
      default: v = DvsW'(30000);
    endcase
    return v;
  endfunction

  function automatic logic [DvsW-1:0] half_of(input logic [2:0] e);
    logic [DvsW-1:0] v;
    case (e)
      3'd0:    v = DvsW'(5);
      3'd1:    v = DvsW'(50);
      3'd2:    v = DvsW'(500);
      3'd3:    v = DvsW'(5000);
      default: v = DvsW'(50000);
    endcase
    return v;
  endfunction

  function automatic logic [DvsW-1:0] div_of(input logic [2:0] e);
    logic [DvsW-1:0] v;
    case (e)
      3'd0:    v = DvsW'(10);
      3'd1:    v = DvsW'(100);
      3'd2:    v = DvsW'(1000);
      3'd3:    v = DvsW'(10000);
      default: v = DvsW'(100000);
    endcase
    return v;
  endfunction

endpackage

[sv/srr_in_if.sv]
interface srr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [srr_pkg::SampleW-1:0]   sample;
  logic                                 resend;

  modport source (output valid, output sample, output resend, input ready);
  modport sink   (input valid, input sample, input resend, output ready);
endinterface

[sv/srr_out_if.sv]
interface srr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [srr_pkg::SampleW-1:0]   average;
  logic signed [srr_pkg::SampleW-1:0]   reported_value;
  logic                                 report_valid;
  logic [1:0]                           fan_command;

  modport source (output valid, output average, output reported_value,
                  output report_valid, output fan_command, input ready);
  modport sink   (input valid, input average, input reported_value,
                  input report_valid, input fan_command, output ready);
endinterface

[sv/srr_div.sv]
module srr_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [srr_pkg::DivW-1:0]    dividend_i,
  input  logic [srr_pkg::DvsW-1:0]    divisor_i,
  output logic                        done_o,
  output logic [srr_pkg::DivW-1:0]    quotient_o
);

  localparam int DivW = srr_pkg::DivW;
  localparam int DvsW = srr_pkg::DvsW;

  logic [DvsW-1:0]             rem_q, rem_d;
  logic [DivW-1:0]             quo_q, quo_d;
  logic [DvsW-1:0]             dvs_q;
  logic [srr_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [DvsW:0]               trial;
  logic [DvsW:0]               diff;

  // restoring division, one quotient bit a cycle; dividend shifts out of quo_q
  always_comb begin
    trial = {rem_q, quo_q[DivW-1]};
    diff  = trial - {1'b0, dvs_q};
    if (!diff[DvsW]) begin
      rem_d = diff[DvsW-1:0];
      quo_d = {quo_q[DivW-2:0], 1'b1};
    end else begin
      rem_d = trial[DvsW-1:0];
      quo_d = {quo_q[DivW-2:0], 1'b0};
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      cnt_d  = srr_pkg::DivCntW'(DivW);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == srr_pkg::DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[sv/srr_datapath.sv]
module srr_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [srr_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [srr_pkg::CfgW-1:0]            cfg_data_i,
  input  logic signed [srr_pkg::SampleW-1:0]  sample_i,
  input  logic                                resend_i,
  input  srr_pkg::srr_cmd_t                   cmd_i,
  output srr_pkg::srr_status_t                status_o,
  output logic signed [srr_pkg::SampleW-1:0]  avg_o,
  output logic signed [srr_pkg::SampleW-1:0]  rep_value_o,
  output logic                                rep_valid_o,
  output logic [1:0]                          fan_cmd_o
);

  localparam int SW    = srr_pkg::SampleW;
  localparam int DivW  = srr_pkg::DivW;
  localparam int DvsW  = srr_pkg::DvsW;
  localparam int NumW  = srr_pkg::NumW;
  localparam int V10W  = srr_pkg::V10W;
  localparam int MagW  = srr_pkg::MagW;
  localparam int CmpW  = srr_pkg::CmpW;
  localparam int StepW = srr_pkg::StepW;

  localparam logic [MagW-1:0]        HiMag = MagW'({(SW-1){1'b1}});
  localparam logic [MagW-1:0]        LoMag = HiMag + 1'b1;
  localparam logic signed [SW-1:0]   HiVal = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0]   LoVal = {1'b1, {(SW-1){1'b0}}};

  // configuration
  logic [srr_pkg::DampW-1:0]          damp_q;
  logic signed [srr_pkg::PlacesW-1:0] places_q;
  logic [srr_pkg::ThrW-1:0]           thr_q;

  // block state
  logic signed [SW-1:0]     avg_q, avg_d;
  logic signed [SW-1:0]     last_q, last_d;
  logic                     rep_ok_q, rep_ok_d;
  srr_pkg::fan_state_e      fan_q, fan_d;

  // working registers
  logic signed [SW-1:0]     sample_q;
  logic [srr_pkg::ProdW-1:0] prod_q;
  logic                     sign_q;
  logic                     hold_q;
  logic [MagW-1:0]          scaled_q;

  // result word
  logic signed [SW-1:0]     out_avg_q;
  logic signed [SW-1:0]     out_rep_q;
  logic                     out_repv_q;
  logic [1:0]               out_fan_q;

  logic [2:0]               exp;
  logic [DvsW-1:0]          step_val;
  logic signed [NumW-1:0]   num;
  logic signed [NumW-1:0]   num_neg;
  logic [DivW-1:0]          num_mag;
  logic signed [V10W-1:0]   avg_ext, last_ext, v10, l10, hamt, v10a, v10n;
  logic                     hold;
  logic [V10W-1:0]          mag2, dvd2;
  logic [DivW-1:0]          div_dvd;
  logic [DvsW-1:0]          div_dvs;
  logic                     div_start;
  logic                     div_done;
  logic [DivW-1:0]          quot;
  logic signed [SW-1:0]     quot_s;
  logic signed [SW-1:0]     rnd;
  logic                     rep;
  logic signed [CmpW-1:0]   avg_c, thr_c;
  srr_pkg::fan_cmd_e        fan_cmd;

  assign exp      = srr_pkg::places_exp(places_q);
  assign step_val = srr_pkg::step_of(exp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      damp_q   <= srr_pkg::DampReset;
      places_q <= srr_pkg::PlacesReset;
      thr_q    <= srr_pkg::ThrReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        srr_pkg::CfgDamping:   damp_q   <= cfg_data_i[srr_pkg::DampW-1:0];
        srr_pkg::CfgPlaces:    places_q <= $signed(cfg_data_i[srr_pkg::PlacesW-1:0]);
        srr_pkg::CfgThreshold: thr_q    <= cfg_data_i[srr_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  // smoothing numerator: average*damping + sample
  always_comb begin
    num     = $signed(NumW'(prod_q)) + NumW'(sample_q);
    num_neg = -num;
    num_mag = num[NumW-1] ? num_neg[DivW-1:0] : num[DivW-1:0];
  end

  // hysteresis in thousandths so that 0.3 of a step is exact
  always_comb begin
    avg_ext  = V10W'(avg_q);
    last_ext = V10W'(last_q);
    v10      = (avg_ext <<< 3) + (avg_ext <<< 1);
    l10      = (last_ext <<< 3) + (last_ext <<< 1);
    hamt     = $signed(V10W'(srr_pkg::hyst_of(exp)));
    v10a     = v10;
    hold     = 1'b0;
    if (rep_ok_q) begin
      if (v10 < l10) begin
        v10a = v10 + hamt;
        hold = v10a > l10;
      end else if (v10 > l10) begin
        v10a = v10 - hamt;
        hold = v10a < l10;
      end
    end
    v10n = -v10a;
    mag2 = v10a[V10W-1] ? v10n : v10a;
    dvd2 = mag2 + V10W'(srr_pkg::half_of(exp));
  end

  assign div_start = cmd_i.div1_start | (cmd_i.hyst & ~hold);
  assign div_dvd   = cmd_i.div1_start ? num_mag : DivW'(dvd2);
  assign div_dvs   = cmd_i.div1_start ? DvsW'({1'b0, damp_q} + 1'b1)
                                      : srr_pkg::div_of(exp);

  srr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  assign quot_s = quot[SW-1:0];

  // rounded value with saturation to the sample range
  always_comb begin
    if (!sign_q) begin
      rnd = (scaled_q > HiMag) ? HiVal : scaled_q[SW-1:0];
    end else begin
      rnd = (scaled_q > LoMag) ? LoVal : -$signed(scaled_q[SW-1:0]);
    end
    rep = ~hold_q & ~(rep_ok_q & (rnd == last_q));
  end

  always_comb begin
    avg_c   = CmpW'(avg_q);
    thr_c   = $signed(CmpW'(thr_q));
    fan_cmd = srr_pkg::FanNone;
    fan_d   = fan_q;
    if (avg_c > thr_c && fan_q != srr_pkg::FanIsOn) begin
      fan_cmd = srr_pkg::FanOn;
      fan_d   = srr_pkg::FanIsOn;
    end else if (avg_c < thr_c && fan_q != srr_pkg::FanIsOff) begin
      fan_cmd = srr_pkg::FanOff;
      fan_d   = srr_pkg::FanIsOff;
    end
  end

  always_comb begin
    avg_d    = avg_q;
    last_d   = last_q;
    rep_ok_d = rep_ok_q;
    if (cmd_i.mul && avg_q[SW-1]) avg_d = sample_q;
    if (cmd_i.avg_take) avg_d = sign_q ? -quot_s : quot_s;
    if (cmd_i.load && resend_i) rep_ok_d = 1'b0;
    if (cmd_i.finish && rep) begin
      last_d   = rnd;
      rep_ok_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q    <= srr_pkg::NoSample;
      last_q   <= srr_pkg::NoSample;
      rep_ok_q <= 1'b0;
      fan_q    <= srr_pkg::FanUnknown;
    end else begin
      avg_q    <= avg_d;
      last_q   <= last_d;
      rep_ok_q <= rep_ok_d;
      if (cmd_i.load && resend_i) fan_q <= srr_pkg::FanUnknown;
      else if (cmd_i.finish)      fan_q <= fan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) sample_q <= sample_i;
    if (cmd_i.mul) prod_q <= avg_q[SW-2:0] * damp_q;
    if (cmd_i.div1_start) sign_q <= num[NumW-1];
    if (cmd_i.hyst) begin
      sign_q <= v10a[V10W-1];
      hold_q <= hold;
    end
    if (cmd_i.scale) scaled_q <= quot[SW-1:0] * step_val[StepW-1:0];
    if (cmd_i.finish) begin
      out_avg_q  <= avg_q;
      out_rep_q  <= rep ? rnd : last_q;
      out_repv_q <= rep;
      out_fan_q  <= fan_cmd;
    end
  end

  assign status_o.avg_neg  = avg_q[SW-1];
  assign status_o.hold     = hold;
  assign status_o.div_done = div_done;

  assign avg_o       = out_avg_q;
  assign rep_value_o = out_rep_q;
  assign rep_valid_o = out_repv_q;
  assign fan_cmd_o   = out_fan_q;

endmodule

[sv/srr_ctrl.sv]
module srr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  input  srr_pkg::srr_status_t  status_i,
  output srr_pkg::srr_cmd_t     cmd_o
);

  srr_pkg::srr_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                out_free;

  // a finished word may only go out once the previous one has been taken
  assign out_free = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      srr_pkg::StIdle:      if (in_valid_i) state_d = srr_pkg::StMul;
      srr_pkg::StMul:       state_d = status_i.avg_neg ? srr_pkg::StHyst
                                                       : srr_pkg::StDiv1Start;
      srr_pkg::StDiv1Start: state_d = srr_pkg::StDiv1Wait;
      srr_pkg::StDiv1Wait:  if (status_i.div_done) state_d = srr_pkg::StHyst;
      srr_pkg::StHyst:      state_d = status_i.hold ? srr_pkg::StFinish
                                                    : srr_pkg::StDiv2Wait;
      srr_pkg::StDiv2Wait:  if (status_i.div_done) state_d = srr_pkg::StScale;
      srr_pkg::StScale:     state_d = srr_pkg::StFinish;
      srr_pkg::StFinish:    if (out_free) state_d = srr_pkg::StIdle;
      default:              state_d = srr_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      srr_pkg::StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      srr_pkg::StMul:       cmd_o.mul        = 1'b1;
      srr_pkg::StDiv1Start: cmd_o.div1_start = 1'b1;
      srr_pkg::StDiv1Wait:  cmd_o.avg_take   = status_i.div_done;
      srr_pkg::StHyst:      cmd_o.hyst       = 1'b1;
      srr_pkg::StDiv2Wait:  ;
      srr_pkg::StScale:     cmd_o.scale      = 1'b1;
      srr_pkg::StFinish:    cmd_o.finish     = out_free;
      default:              ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srr_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[sv/smoothed_reading_reporter_core.sv]
// Channel  Dir  Word
// in_i     in   sample (signed hundredths), resend
// out_o    out  average, reported_value, report_valid, fan_command
// cfg      in   cfg_we_i / cfg_idx_i / cfg_data_i, write only
//
// One word at a time. The shared bit-serial divider sets the pace: one
// pass for the smoothing division, one for the rounding. A negative
// average (as at reset) skips the smoothing pass and takes the sample as
// the average; a word held inside the band skips the rounding pass.
// The result register frees the input side; a word waits in the finish
// state only while the previous result is still untaken.
// Reset is asynchronous and active low; no clearing pass.
`include "assert_macros.svh"

module smoothed_reading_reporter_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  srr_in_if.sink                       in_i,
  srr_out_if.source                    out_o,
  input  logic                         cfg_we_i,
  input  logic [srr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [srr_pkg::CfgW-1:0]     cfg_data_i
);

  srr_pkg::srr_cmd_t    cmd;
  srr_pkg::srr_status_t status;
  logic                 in_ready;
  logic                 out_valid;

  srr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  srr_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (in_i.sample),
    .resend_i    (in_i.resend),
    .cmd_i       (cmd),
    .status_o    (status),
    .avg_o       (out_o.average),
    .rep_value_o (out_o.reported_value),
    .rep_valid_o (out_o.report_valid),
    .fan_cmd_o   (out_o.fan_command)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

  `SRR_ASSERT_NXT(a_busy_after_take, clk_i, rst_ni, in_i.valid && in_i.ready,
                  !in_i.ready, "word taken while busy")
  `SRR_ASSERT_IMP(a_finish_free, clk_i, rst_ni, cmd.finish,
                  !out_valid || out_o.ready, "result overwritten")
  `SRR_ASSERT_NXT(a_finish_shows, clk_i, rst_ni, cmd.finish, out_valid,
                  "finished word not presented")
  `SRR_ASSERT_IMP(a_fan_code, clk_i, rst_ni, out_valid,
                  out_o.fan_command == srr_pkg::FanNone ||
                  out_o.fan_command == srr_pkg::FanOn ||
                  out_o.fan_command == srr_pkg::FanOff, "bad fan command")

endmodule
